// File: rtl/chit_pkg.sv
`default_nettype none

package chit_pkg;

   localparam int KEY_W           = 32;
   localparam int FRAME_W         = 10;
   localparam int LINK_W          = FRAME_W + 1;
   localparam int MAX_BUCKET_BITS = 12;
   localparam int BUCKET_W        = MAX_BUCKET_BITS;
   localparam int BITS_W          = 4;
   localparam int ENTRY_COUNT     = 1 << FRAME_W;
   localparam int BUCKET_COUNT    = 1 << MAX_BUCKET_BITS;
   localparam int STEP_W          = FRAME_W + 1;

   localparam logic [LINK_W-1:0]   NIL_LINK    = LINK_W'(ENTRY_COUNT);
   localparam logic [BITS_W-1:0]   BITS_RESET  = BITS_W'(MAX_BUCKET_BITS);

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_READ,
      S_ADD_LINK,
      S_ADD_TAIL,
      S_RM_READ,
      S_RM_UNLINK,
      S_LK_HEAD,
      S_LK_FIRST,
      S_LK_WALK,
      S_RESP
   } state_type;

   typedef struct packed {
      req_code_type          code;
      logic [KEY_W-1:0]      key;
      logic [FRAME_W-1:0]    frame;
      logic [BUCKET_W-1:0]   bucket;
   } request_type;

   typedef struct packed {
      status_type            status;
      logic [FRAME_W-1:0]    found;
      logic [BUCKET_W-1:0]   bucket;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/chained_hash_index_table_unit.sv
`default_nettype none

// Channel    Direction  Handshake              Payload
// req        in         req_valid/req_ready    req_type, req_key, req_frame_index
// rsp        out        rsp_valid/rsp_ready    rsp_status, rsp_found_frame, rsp_bucket_index
// csr        in         csr_wr_en              csr_wr_data (bucket bits)
//
// After reset the engine steps through all 4096 bucket addresses to clear the bucket heads,
// tails and entry flags, during which no item is taken.
// An add reads, links and may update the old tail; a remove reads and unlinks; a lookup
// reads the head and one chain entry per step: one read port per table, one key comparator.
// A finished item waits in the output register while the next item is accepted.

module chained_hash_index_table_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_type,
   input  wire logic [chit_pkg::KEY_W-1:0]      req_key,
   input  wire logic [chit_pkg::FRAME_W-1:0]    req_frame_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [chit_pkg::FRAME_W-1:0]         rsp_found_frame,
   output logic [chit_pkg::BUCKET_W-1:0]        rsp_bucket_index,
   input  wire logic                            csr_wr_en,
   input  wire logic [chit_pkg::BITS_W-1:0]     csr_wr_data
);
   import chit_pkg::*;

   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;
   logic [BUCKET_W-1:0] hash_bucket;
   request_type         request;
   result_type          result;
   logic                idle, out_free, out_load, accept;

   chit_hash u_hash (
      .key         (req_key),
      .bucket_bits (bits_ff),
      .bucket      (hash_bucket)
   );

   assign request = '{code: req_code_type'(req_type), key: req_key,
                      frame: req_frame_index, bucket: hash_bucket};
   assign accept   = req_valid && idle;
   assign out_free = !rsp_valid_ff || rsp_ready;

   chit_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .req      (request),
      .idle     (idle),
      .out_free (out_free),
      .out_load (out_load),
      .result   (result)
   );

   always_comb begin
      bits_in      = csr_wr_en ? csr_wr_data : bits_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_in       = out_load ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff      <= BITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_ready        = idle;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_found_frame  = rsp_ff.found;
   assign rsp_bucket_index = rsp_ff.bucket;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block took a second item in the cycle after an accept");

   a_miss_no_frame : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_MISS) |-> rsp_found_frame == '0)
      else $error("lookup miss carries a frame");

   a_invalid_no_frame : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_INVALID) |-> rsp_found_frame == '0)
      else $error("invalid item carries a frame");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result overwrote one that was not taken");

endmodule

`default_nettype wire

// File: rtl/chit_hash.sv
`default_nettype none

module chit_hash (
   input  wire logic [chit_pkg::KEY_W-1:0]    key,
   input  wire logic [chit_pkg::BITS_W-1:0]   bucket_bits,
   output logic      [chit_pkg::BUCKET_W-1:0] bucket
);
   import chit_pkg::*;

   logic [BITS_W-1:0]   bits_used;
   logic [KEY_W-1:0]    folded;
   logic [KEY_W-1:0]    mixed;
   logic [BUCKET_W-1:0] mask;

   always_comb begin
      if (bucket_bits == '0) begin
         bits_used = BITS_W'(1);
      end else if (bucket_bits > BITS_RESET) begin
         bits_used = BITS_RESET;
      end else begin
         bits_used = bucket_bits;
      end

      if (bits_used <= BITS_W'(4)) begin
         folded = key ^ (key >> 8) ^ (key >> 16) ^ (key >> 24);
      end else if (bits_used <= BITS_W'(8)) begin
         folded = key ^ (key >> 16);
      end else begin
         folded = key;
      end

      mixed  = folded ^ (folded >> bits_used);
      mask   = {BUCKET_W{1'b1}} >> (BITS_RESET - bits_used);
      bucket = mixed[BUCKET_W-1:0] & mask;
   end

endmodule

`default_nettype wire

// File: rtl/chit_engine.sv
`default_nettype none

module chit_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire chit_pkg::request_type req,
   output logic                       idle,
   input  wire logic                  out_free,
   output logic                       out_load,
   output chit_pkg::result_type       result
);
   import chit_pkg::*;

   logic [LINK_W-1:0]   head_mem [BUCKET_COUNT];
   logic [LINK_W-1:0]   tail_mem [BUCKET_COUNT];
   logic                inuse_mem [ENTRY_COUNT];
   logic [KEY_W-1:0]    key_mem [ENTRY_COUNT];
   logic [LINK_W-1:0]   next_mem [ENTRY_COUNT];
   logic [LINK_W-1:0]   prev_mem [ENTRY_COUNT];
   logic [BUCKET_W-1:0] bkt_mem [ENTRY_COUNT];

   logic [LINK_W-1:0]   head_rd, tail_rd, next_rd, prev_rd;
   logic                inuse_rd;
   logic [KEY_W-1:0]    key_rd;
   logic [BUCKET_W-1:0] bkt_rd;

   logic                head_we, tail_we, inuse_we, key_we, next_we, prev_we, bkt_we;
   logic [BUCKET_W-1:0] head_wa, tail_wa;
   logic [FRAME_W-1:0]  inuse_wa, key_wa, next_wa, prev_wa, bkt_wa;
   logic [LINK_W-1:0]   head_wd, tail_wd, next_wd, prev_wd;
   logic                inuse_wd;
   logic [FRAME_W-1:0]  walk_addr, next_ra;

   state_type           state_ff, state_in;
   request_type         req_ff, req_in;
   logic [BUCKET_W-1:0] clr_ff, clr_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   result_type          res_ff, res_in;

   logic                walk_hit, walk_end;
   logic [STEP_W-1:0]   steps_next;

   assign walk_addr  = (state_ff == S_LK_FIRST) ? head_rd[FRAME_W-1:0]
                                                : next_rd[FRAME_W-1:0];
   assign next_ra    = (state_ff == S_RM_READ) ? req_ff.frame : walk_addr;
   assign steps_next = steps_ff + STEP_W'(1);
   assign walk_hit   = (key_rd == req_ff.key);
   assign walk_end   = next_rd[FRAME_W] || (steps_next == STEP_W'(ENTRY_COUNT));

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd <= head_mem[req_ff.bucket];
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[tail_wa] <= tail_wd;
      end
      tail_rd <= tail_mem[req_ff.bucket];
   end

   always_ff @(posedge clock) begin
      if (inuse_we) begin
         inuse_mem[inuse_wa] <= inuse_wd;
      end
      inuse_rd <= inuse_mem[req_ff.frame];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= req_ff.key;
      end
      key_rd <= key_mem[walk_addr];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_rd <= next_mem[next_ra];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      prev_rd <= prev_mem[req_ff.frame];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= req_ff.bucket;
      end
      bkt_rd <= bkt_mem[req_ff.frame];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      req_ff   <= req_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == BUCKET_W'(BUCKET_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req.code)
                  REQ_ADD:    state_in = S_ADD_READ;
                  REQ_REMOVE: state_in = S_RM_READ;
                  REQ_LOOKUP: state_in = S_LK_HEAD;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_ADD_READ: state_in = S_ADD_LINK;
         S_ADD_LINK: begin
            state_in = (!inuse_rd && !tail_rd[FRAME_W]) ? S_ADD_TAIL : S_RESP;
         end
         S_ADD_TAIL:  state_in = S_RESP;
         S_RM_READ:   state_in = S_RM_UNLINK;
         S_RM_UNLINK: state_in = S_RESP;
         S_LK_HEAD:   state_in = S_LK_FIRST;
         S_LK_FIRST:  state_in = head_rd[FRAME_W] ? S_RESP : S_LK_WALK;
         S_LK_WALK: begin
            if (walk_hit || walk_end) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      idle     = 1'b0;
      out_load = 1'b0;
      req_in   = req_ff;
      clr_in   = clr_ff;
      cur_in   = cur_ff;
      steps_in = steps_ff;
      res_in   = res_ff;
      head_we  = 1'b0;
      tail_we  = 1'b0;
      inuse_we = 1'b0;
      key_we   = 1'b0;
      next_we  = 1'b0;
      prev_we  = 1'b0;
      bkt_we   = 1'b0;
      head_wa  = req_ff.bucket;
      tail_wa  = req_ff.bucket;
      inuse_wa = req_ff.frame;
      key_wa   = req_ff.frame;
      next_wa  = req_ff.frame;
      prev_wa  = req_ff.frame;
      bkt_wa   = req_ff.frame;
      head_wd  = {1'b0, req_ff.frame};
      tail_wd  = {1'b0, req_ff.frame};
      next_wd  = NIL_LINK;
      prev_wd  = tail_rd;
      inuse_wd = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in   = clr_ff + BUCKET_W'(1);
            head_we  = 1'b1;
            tail_we  = 1'b1;
            inuse_we = 1'b1;
            head_wa  = clr_ff;
            tail_wa  = clr_ff;
            inuse_wa = clr_ff[FRAME_W-1:0];
            head_wd  = NIL_LINK;
            tail_wd  = NIL_LINK;
            inuse_wd = 1'b0;
         end
         S_IDLE: begin
            idle   = 1'b1;
            req_in = req;
            res_in = '{status: STATUS_INVALID, found: '0, bucket: '0};
         end
         S_ADD_READ: begin
            res_in.bucket = req_ff.bucket;
         end
         S_ADD_LINK: begin
            cur_in = tail_rd;
            if (!inuse_rd) begin
               res_in.status = STATUS_OK;
               key_we   = 1'b1;
               bkt_we   = 1'b1;
               next_we  = 1'b1;
               prev_we  = 1'b1;
               inuse_we = 1'b1;
               tail_we  = 1'b1;
               head_we  = tail_rd[FRAME_W];
            end
         end
         S_ADD_TAIL: begin
            next_we = 1'b1;
            next_wa = cur_ff[FRAME_W-1:0];
            next_wd = {1'b0, req_ff.frame};
         end
         S_RM_READ: begin
            res_in.bucket = '0;
         end
         S_RM_UNLINK: begin
            if (inuse_rd) begin
               res_in.status = STATUS_OK;
               res_in.bucket = bkt_rd;
               inuse_we = 1'b1;
               inuse_wd = 1'b0;
               head_wa  = bkt_rd;
               tail_wa  = bkt_rd;
               head_wd  = next_rd;
               tail_wd  = prev_rd;
               head_we  = prev_rd[FRAME_W];
               tail_we  = next_rd[FRAME_W];
               next_we  = !prev_rd[FRAME_W];
               next_wa  = prev_rd[FRAME_W-1:0];
               next_wd  = next_rd;
               prev_we  = !next_rd[FRAME_W];
               prev_wa  = next_rd[FRAME_W-1:0];
               prev_wd  = prev_rd;
            end
         end
         S_LK_HEAD: begin
            res_in.status = STATUS_MISS;
            res_in.bucket = req_ff.bucket;
         end
         S_LK_FIRST: begin
            cur_in   = {1'b0, walk_addr};
            steps_in = '0;
         end
         S_LK_WALK: begin
            cur_in   = {1'b0, walk_addr};
            steps_in = steps_next;
            if (walk_hit) begin
               res_in.status = STATUS_OK;
               res_in.found  = cur_ff[FRAME_W-1:0];
            end
         end
         S_RESP: begin
            out_load = out_free;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
   import chit_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic [FRAME_W-1:0] found;
      logic [BUCKET_W-1:0] bucket;
   } hash_result_type;

   class hash_index_scoreboard;
      logic [LINK_W-1:0]   head_q [BUCKET_COUNT];
      logic [LINK_W-1:0]   tail_q [BUCKET_COUNT];
      logic [KEY_W-1:0]    key_q [ENTRY_COUNT];
      logic [LINK_W-1:0]   next_q [ENTRY_COUNT];
      logic [LINK_W-1:0]   prev_q [ENTRY_COUNT];
      logic [BUCKET_W-1:0] bkt_q [ENTRY_COUNT];
      bit                  used_q [ENTRY_COUNT];
      logic [BITS_W-1:0]   bucket_bits;
      hash_result_type     pending_results [$];
      int                  error_count;

      function new();
         for (int i = 0; i < BUCKET_COUNT; i++) begin
            head_q[i] = NIL_LINK;
            tail_q[i] = NIL_LINK;
         end
         for (int i = 0; i < ENTRY_COUNT; i++) used_q[i] = 0;
         bucket_bits = BITS_RESET;
         error_count = 0;
      endfunction

      function logic [BUCKET_W-1:0] hash_key(logic [KEY_W-1:0] k);
         int unsigned b;
         logic [31:0] h;
         b = bucket_bits;
         if (b < 1) b = 1;
         if (b > MAX_BUCKET_BITS) b = MAX_BUCKET_BITS;
         if (b <= 4) h = k ^ (k >> 8) ^ (k >> 16) ^ (k >> 24);
         else if (b <= 8) h = k ^ (k >> 16);
         else h = k;
         h = h ^ (h >> b);
         return BUCKET_W'(h & ((32'd1 << b) - 1));
      endfunction

      function void note_request(logic [1:0] code, logic [KEY_W-1:0] k,
                                 logic [FRAME_W-1:0] f);
         hash_result_type r;
         logic [LINK_W-1:0] t, p, n, cur;
         int steps;
         r.status = STATUS_INVALID;
         r.found = '0;
         r.bucket = '0;
         if (code == REQ_ADD) begin
            r.bucket = hash_key(k);
            if (!used_q[f]) begin
               t = tail_q[r.bucket];
               key_q[f] = k;
               bkt_q[f] = r.bucket;
               next_q[f] = NIL_LINK;
               prev_q[f] = t;
               if (t != NIL_LINK) next_q[t[FRAME_W-1:0]] = LINK_W'(f);
               else head_q[r.bucket] = LINK_W'(f);
               tail_q[r.bucket] = LINK_W'(f);
               used_q[f] = 1;
               r.status = STATUS_OK;
            end
         end else if (code == REQ_REMOVE) begin
            if (used_q[f]) begin
               p = prev_q[f];
               n = next_q[f];
               r.bucket = bkt_q[f];
               if (p != NIL_LINK) next_q[p[FRAME_W-1:0]] = n;
               else head_q[r.bucket] = n;
               if (n != NIL_LINK) prev_q[n[FRAME_W-1:0]] = p;
               else tail_q[r.bucket] = p;
               used_q[f] = 0;
               r.status = STATUS_OK;
            end
         end else if (code == REQ_LOOKUP) begin
            r.bucket = hash_key(k);
            r.status = STATUS_MISS;
            cur = head_q[r.bucket];
            steps = 0;
            while (cur != NIL_LINK && steps < ENTRY_COUNT) begin
               if (key_q[cur[FRAME_W-1:0]] == k) begin
                  r.status = STATUS_OK;
                  r.found = cur[FRAME_W-1:0];
                  break;
               end
               cur = next_q[cur[FRAME_W-1:0]];
               steps++;
            end
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [1:0] s, logic [FRAME_W-1:0] f,
                                 logic [BUCKET_W-1:0] b);
         hash_result_type e;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d frame=%0d bucket=%0d",
                     $time, s, f, b);
            error_count++;
            return;
         end
         e = pending_results.pop_front();
         if (s !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, s);
            error_count++;
         end
         if (f !== e.found) begin
            $display("%0t: found_frame expected %0d actual %0d", $time, e.found, f);
            error_count++;
         end
         if (b !== e.bucket) begin
            $display("%0t: bucket_index expected %0d actual %0d", $time, e.bucket, b);
            error_count++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic [1:0]          req_type = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [FRAME_W-1:0]  req_frame_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [1:0]          rsp_status;
   logic [FRAME_W-1:0]  rsp_found_frame;
   logic [BUCKET_W-1:0] rsp_bucket_index;
   logic                csr_wr_en = 0;
   logic [BITS_W-1:0]   csr_wr_data = '0;

   hash_index_scoreboard board = new();
   logic [KEY_W-1:0]    key_pool [16];
   int                  cycle_count = 0;
   int                  rsp_hold = 0;
   bit                  sending_done = 0;

   chained_hash_index_table_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_key(req_key), .req_frame_index(req_frame_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_found_frame(rsp_found_frame), .rsp_bucket_index(rsp_bucket_index),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The result side stalls at random, now and then for a long stretch.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_status, rsp_found_frame, rsp_bucket_index);
      if (reset) begin
         rsp_ready <= 0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 0;
         rsp_hold <= rsp_hold - 1;
      end else if (!sending_done && $urandom_range(0, 99) < 2) begin
         rsp_ready <= 0;
         rsp_hold <= $urandom_range(10, 40);
      end else if ($urandom_range(0, 99) < 40 && !sending_done) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 99) < 90) || sending_done;
   end

   task automatic send_request(logic [1:0] code, logic [KEY_W-1:0] k,
                               logic [FRAME_W-1:0] f);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= code;
      req_key <= k;
      req_frame_index <= f;
      do @(posedge clock); while (!req_ready);
      board.note_request(code, k, f);
   endtask

   task automatic write_bucket_bits(logic [BITS_W-1:0] v);
      req_valid <= 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      board.bucket_bits = v;
   endtask

   task automatic random_phase(int count);
      int r;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 15)];
         if (r < 40) send_request(REQ_ADD, k, FRAME_W'($urandom_range(0, 63)));
         else if (r < 65) send_request(REQ_REMOVE, k, FRAME_W'($urandom_range(0, 63)));
         else if (r < 97) send_request(REQ_LOOKUP, k, FRAME_W'($urandom()));
         else send_request(REQ_NONE, $urandom(), FRAME_W'($urandom()));
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      repeat (9) @(posedge clock);
      reset <= 0;
      send_request(REQ_ADD, 32'h0, 10'd0);
      send_request(REQ_ADD, 32'hFFFF_FFFF, 10'd1023);
      send_request(REQ_ADD, 32'h0, 10'd5);
      send_request(REQ_ADD, 32'h1234_5678, 10'd0);
      send_request(REQ_LOOKUP, 32'h0, 10'd0);
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
      send_request(REQ_LOOKUP, 32'h1234_5678, 10'd0);
      send_request(REQ_REMOVE, 32'h0, 10'd0);
      send_request(REQ_LOOKUP, 32'h0, 10'd0);
      send_request(REQ_REMOVE, 32'h0, 10'd0);
      send_request(REQ_REMOVE, 32'h0, 10'd777);
      send_request(REQ_NONE, 32'hFFFF_FFFF, 10'd1023);
      write_bucket_bits(4'd0);
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
      send_request(REQ_ADD, 32'hA5A5_5A5A, 10'd7);
      write_bucket_bits(4'd15);
      send_request(REQ_LOOKUP, 32'hA5A5_5A5A, 10'd0);
      send_request(REQ_REMOVE, 32'h0, 10'd7);
      send_request(REQ_REMOVE, 32'h0, 10'd5);
      send_request(REQ_REMOVE, 32'h0, 10'd1023);
      random_phase(400);
      write_bucket_bits(4'd1);
      random_phase(400);
      write_bucket_bits(4'd4);
      random_phase(300);
      write_bucket_bits(4'd6);
      random_phase(300);
      write_bucket_bits(4'd8);
      random_phase(300);
      write_bucket_bits(4'd12);
      random_phase(300);
      req_valid <= 0;
      sending_done = 1;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
